### design/kdlp_pkg.sv
// kdlp_pkg: shared types and constants for the key debounce / long press block.
// No dependencies.
package kdlp_pkg;

	localparam int KEY_W   = 4;
	localparam int CODE_W  = 3;
	localparam int TICK_W  = 8;
	localparam int CFG_W   = 8;
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 8;

	localparam logic [KEY_W-1:0] KEYS_UP = 4'hf;
	localparam logic [KEY_W-1:0] KEY1_DN = 4'he;
	localparam logic [KEY_W-1:0] KEY2_DN = 4'hd;
	localparam logic [KEY_W-1:0] KEY3_DN = 4'hb;
	localparam logic [KEY_W-1:0] KEY4_DN = 4'h7;

	localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;
	localparam logic [CODE_W-1:0] CODE_KEY1 = 3'd1;
	localparam logic [CODE_W-1:0] CODE_KEY2 = 3'd2;
	localparam logic [CODE_W-1:0] CODE_KEY3 = 3'd3;
	localparam logic [CODE_W-1:0] CODE_KEY4 = 3'd4;

	localparam logic [TICK_W-1:0] TICK_MAX     = 8'hff;
	localparam logic [CFG_W-1:0]  DEBOUNCE_RST = 8'd3;
	localparam logic [CFG_W-1:0]  LONG_RST     = 8'd100;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_DEBOUNCE = 2'd1,
		PH_HELD     = 2'd2,
		PH_WAIT     = 2'd3
	} phase_t;

	typedef enum logic {
		REG_DEBOUNCE = 1'b0,
		REG_LONG     = 1'b1
	} reg_idx_t;

endpackage

### design/key_debounce_long_press_top.sv
// key_debounce_long_press_top: debounce of four active-low keys with short/long press report.
// Depends on kdlp_pkg.
//
// One scan tick enters per item and yields exactly one result item (code 0 with no
// long flag means no event). The tick is decoded against the phase register and
// the press counter in a single pass and lands in the output register, so a new
// tick is accepted every cycle as long as the output register is empty or being
// drained in the same cycle. m_tvalid rises in the cycle after accept. The user
// must write thresholds through the cfg port only while idle; the block does not enforce it.
module key_debounce_long_press_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [kdlp_pkg::S_TDATA_W-1:0]   s_tdata,  // [3:0] key_levels, [7:4] zero
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [kdlp_pkg::M_TDATA_W-1:0]   m_tdata,  // [2:0] key_code, [7:3] zero
	output logic                             m_tuser,  // [0] long_press
	// configuration
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [kdlp_pkg::CFG_W-1:0]       cfg_data
);
	import kdlp_pkg::*;

	logic [CFG_W-1:0]  debounce_q, long_q;
	phase_t            phase_q, phase_d;
	logic [TICK_W-1:0] press_q, press_d, press_inc;
	logic [CODE_W-1:0] latch_q, latch_d, latch_held;
	logic [CODE_W-1:0] code_d, code_q;
	logic              long_d, long_q_out;
	logic              valid_q;
	logic [KEY_W-1:0]  keys;
	logic              accept;

	assign keys     = s_tdata[KEY_W-1:0];
	assign s_tready = !valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign press_inc = (press_q == TICK_MAX) ? press_q : press_q + 8'd1;

	always_comb begin
		case (keys)
			KEY1_DN: latch_held = CODE_KEY1;
			KEY2_DN: latch_held = CODE_KEY2;
			KEY3_DN: latch_held = CODE_KEY3;
			KEY4_DN: latch_held = CODE_KEY4;
			default: latch_held = latch_q;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		press_d = press_q;
		latch_d = latch_q;
		code_d  = CODE_NONE;
		long_d  = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				latch_d = CODE_NONE;
				if (keys != KEYS_UP) begin
					press_d = '0;
					phase_d = PH_DEBOUNCE;
				end
			end
			PH_DEBOUNCE: begin
				if (keys != KEYS_UP) begin
					press_d = press_inc;
					if (press_inc >= debounce_q)
						phase_d = PH_HELD;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_HELD: begin
				if (keys == KEYS_UP) begin
					code_d  = latch_q;
					latch_d = CODE_NONE;
					phase_d = PH_IDLE;
				end else begin
					press_d = press_inc;
					latch_d = latch_held;
					if (press_inc >= long_q) begin
						code_d  = latch_held;
						long_d  = 1'b1;
						latch_d = CODE_NONE;
						phase_d = PH_WAIT;
					end
				end
			end
			PH_WAIT: begin
				if (keys == KEYS_UP)
					phase_d = PH_IDLE;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			long_q     <= LONG_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_LONG:     long_q     <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			press_q <= '0;
			latch_q <= CODE_NONE;
		end else if (accept) begin
			phase_q <= phase_d;
			press_q <= press_d;
			latch_q <= latch_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (s_tready)
			valid_q <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_q     <= code_d;
			long_q_out <= long_d;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(M_TDATA_W-CODE_W){1'b0}}, code_q};
	assign m_tuser  = long_q_out;

endmodule

### design/kdlp_checker.sv
// kdlp_checker: port-level assertions for key_debounce_long_press_top, plus bind.
// Depends on kdlp_pkg.
module kdlp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [kdlp_pkg::M_TDATA_W-1:0]   m_tdata,
	input logic                             m_tuser
);
	import kdlp_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// every accepted tick yields a result next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted item gave no result");

	// empty output register never blocks input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// reported code is a legal key code, padding zero
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_TDATA_W-1:CODE_W] == '0 && m_tdata[CODE_W-1:0] <= CODE_KEY4)
		else $error("illegal key code");

endmodule

bind key_debounce_long_press_top kdlp_checker u_kdlp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
